[hdl/spp_pkg.sv]
package spp_pkg;

    // Pixel flag bits.
    localparam int FLAG_AVAIL  = 0;
    localparam int FLAG_FILLED = 1;

    // Score of a candidate with no filled neighbor.
    localparam logic [16:0] NO_NEIGHBOUR_SCORE = 17'd131071;

    // Item kinds.
    typedef enum logic {
        KIND_SEED   = 1'b0,
        KIND_SEARCH = 1'b1
    } kind_t;

    // Register indexes.
    localparam logic REG_SCORE_MODE = 1'b0;
    localparam logic REG_GRID_SIDE  = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_NB_RD,
        ST_NB_WAIT,
        ST_NB_ACC,
        ST_DIV,
        ST_CAND,
        ST_PLACE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_OUT
    } state_t;

    // Squared-distance helper on one 8-bit channel.
    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

endpackage

[hdl/spp_if.sv]
interface spp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] seed_x;
    logic [7:0] seed_y;
    modport source (output valid, kind, red, green, blue, seed_x, seed_y, input ready);
    modport sink (input valid, kind, red, green, blue, seed_x, seed_y, output ready);
endinterface

interface spp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  place_x;
    logic [7:0]  place_y;
    logic [16:0] best_score;
    logic        placed;
    modport source (output valid, place_x, place_y, best_score, placed, input ready);
    modport sink (input valid, place_x, place_y, best_score, placed, output ready);
endinterface

interface spp_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [8:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/smoke_pixel_placer.sv]
// Channel   Dir   Payload
// in        sink  kind, red, green, blue, seed_x, seed_y
// out       src   place_x, place_y, best_score, placed
// cfg       sink  index (0 score_mode, 1 grid_side), data
//
// After reset the flag memory is cleared, one entry a cycle: all 4**CW entries (65536 by default).
// A seed item is written and its neighbours marked available. A search item reads every pixel
// of the grid and scores each candidate from its filled neighbours, by minimum or average.
// The colour and flag memories each have a single read port, and a bit-serial divider forms
// the average score. One item is worked at a time; the result register holds the item until
// taken, while the next item may be accepted.
module smoke_pixel_placer
    import spp_pkg::*;
#(
    parameter int GRID_MAX = 256
)
(
    input  logic   clk,
    input  logic   rst_n,
    spp_in_if.sink    in_ch,
    spp_out_if.source out_ch,
    spp_cfg_if.sink   cfg
);

    localparam int CW = (GRID_MAX > 256) ? 8 : $clog2(GRID_MAX);
    localparam int AW = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [8:0] SIDE_CAP = (GRID_MAX > 256) ? 9'd256 : 9'(GRID_MAX);

    // Memories.
    logic [23:0] colour_mem [DEPTH];
    logic [1:0]  flag_mem [DEPTH];
    logic [23:0] colour_rd;
    logic [1:0]  flag_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          flag_we, colour_we;
    logic [1:0]    flag_wd;
    logic [23:0]   colour_wd;

    always_ff @(posedge clk)
    begin
        if (colour_we)
        begin
            colour_mem[wr_addr] <= colour_wd;
        end
        colour_rd <= colour_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[wr_addr] <= flag_wd;
        end
        flag_rd <= flag_mem[rd_addr];
    end

    // Registers.
    state_t      state_reg, state_next;
    logic        mode_reg, mode_next;
    logic [8:0]  gside_reg, gside_next;
    logic [8:0]  side_reg, side_next;
    logic [23:0] col_reg, col_next;
    logic        kind_reg, kind_next;
    logic [8:0]  x_reg, x_next, y_reg, y_next;
    logic [8:0]  px_reg, px_next, py_reg, py_next;
    logic [3:0]  nb_reg, nb_next;
    logic [16:0] mn_reg, mn_next;
    logic [19:0] tot_reg, tot_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [16:0] sc_reg, sc_next;
    logic [16:0] best_reg, best_next;
    logic        found_reg, found_next;
    logic [4:0]  dstep_reg, dstep_next;
    logic [19:0] quo_reg, quo_next;
    logic [4:0]  rem_reg, rem_next;
    logic [AW:0] clr_reg, clr_next;
    logic        ov_reg, ov_next;
    logic [7:0]  ox_reg, ox_next, oy_reg, oy_next;
    logic [16:0] os_reg, os_next;
    logic        op_reg, op_next;

    // Neighbor offset decode: codes 0..8 cover dy,dx in -1..1; code 4 is the center.
    logic [1:0]  nb_col, nb_row;
    logic [9:0]  nbx, nby;
    logic        nb_ok;
    logic [16:0] nb_dist;
    logic [4:0]  rem_sh;
    logic [8:0]  cfg_side;

    always_comb
    begin
        unique case (nb_reg)
            4'd0:    begin nb_col = 2'd0; nb_row = 2'd0; end
            4'd1:    begin nb_col = 2'd1; nb_row = 2'd0; end
            4'd2:    begin nb_col = 2'd2; nb_row = 2'd0; end
            4'd3:    begin nb_col = 2'd0; nb_row = 2'd1; end
            4'd4:    begin nb_col = 2'd1; nb_row = 2'd1; end
            4'd5:    begin nb_col = 2'd2; nb_row = 2'd1; end
            4'd6:    begin nb_col = 2'd0; nb_row = 2'd2; end
            4'd7:    begin nb_col = 2'd1; nb_row = 2'd2; end
            4'd8:    begin nb_col = 2'd2; nb_row = 2'd2; end
            default: begin nb_col = 2'd0; nb_row = 2'd0; end
        endcase
        nbx = {1'b0, x_reg} + 10'(nb_col) - 10'd1;
        nby = {1'b0, y_reg} + 10'(nb_row) - 10'd1;
        nb_ok = (nb_reg != 4'd4) && !nbx[9] && !nby[9] &&
                (nbx[8:0] < side_reg) && (nby[8:0] < side_reg);
        nb_dist = 17'(({2'b0, sq_diff(colour_rd[23:16], col_reg[23:16])} +
                       {2'b0, sq_diff(colour_rd[15:8], col_reg[15:8])} +
                       {2'b0, sq_diff(colour_rd[7:0], col_reg[7:0])}) >> 1);
        rem_sh = {rem_reg[3:0], quo_reg[19]};
        cfg_side = (cfg.data < 9'd2) ? 9'd2 : ((cfg.data > SIDE_CAP) ? SIDE_CAP : cfg.data);
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign out_ch.valid = ov_reg;
    assign out_ch.place_x = ox_reg;
    assign out_ch.place_y = oy_reg;
    assign out_ch.best_score = os_reg;
    assign out_ch.placed = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            mode_reg  <= 1'b0;
            gside_reg <= SIDE_CAP;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            gside_reg <= gside_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next; col_reg <= col_next; kind_reg <= kind_next;
        x_reg <= x_next; y_reg <= y_next; px_reg <= px_next; py_reg <= py_next;
        nb_reg <= nb_next; mn_reg <= mn_next; tot_reg <= tot_next; cnt_reg <= cnt_next;
        sc_reg <= sc_next; best_reg <= best_next; found_reg <= found_next;
        dstep_reg <= dstep_next; quo_reg <= quo_next; rem_reg <= rem_next;
        ox_reg <= ox_next; oy_reg <= oy_next; os_reg <= os_next; op_reg <= op_next;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg; mode_next = mode_reg; gside_next = gside_reg;
        side_next = side_reg; col_next = col_reg; kind_next = kind_reg;
        x_next = x_reg; y_next = y_reg; px_next = px_reg; py_next = py_reg;
        nb_next = nb_reg; mn_next = mn_reg; tot_next = tot_reg; cnt_next = cnt_reg;
        sc_next = sc_reg; best_next = best_reg; found_next = found_reg;
        dstep_next = dstep_reg; quo_next = quo_reg; rem_next = rem_reg;
        clr_next = clr_reg; ov_next = ov_reg;
        ox_next = ox_reg; oy_next = oy_reg; os_next = os_reg; op_next = op_reg;
        rd_addr = AW'({y_reg[CW-1:0], x_reg[CW-1:0]});
        wr_addr = AW'({y_reg[CW-1:0], x_reg[CW-1:0]});
        flag_we = 1'b0; colour_we = 1'b0; flag_wd = 2'b00; colour_wd = col_reg;

        if (cfg.valid)
        begin
            if (cfg.index == REG_SCORE_MODE)
            begin
                mode_next = cfg.data[0];
            end
            else
            begin
                gside_next = cfg_side;
            end
        end
        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_addr = clr_reg[AW-1:0];
                flag_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    side_next = gside_reg;
                    col_next = {in_ch.red, in_ch.green, in_ch.blue};
                    kind_next = in_ch.kind;
                    found_next = 1'b0;
                    best_next = '0;
                    if (in_ch.kind == KIND_SEED)
                    begin
                        px_next = {1'b0, in_ch.seed_x};
                        py_next = {1'b0, in_ch.seed_y};
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        x_next = '0; y_next = '0;
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (flag_rd[FLAG_AVAIL] && !flag_rd[FLAG_FILLED])
                begin
                    nb_next = '0; cnt_next = '0; tot_next = '0;
                    mn_next = NO_NEIGHBOUR_SCORE;
                    state_next = ST_NB_RD;
                end
                else
                begin
                    state_next = ST_CAND;
                    sc_next = NO_NEIGHBOUR_SCORE;
                    found_next = found_reg;
                    dstep_next = 5'd31;
                end
            end
            ST_NB_RD:
            begin
                rd_addr = AW'({nby[CW-1:0], nbx[CW-1:0]});
                if (nb_reg == 4'd9)
                begin
                    state_next = ST_DIV;
                    quo_next = tot_reg; rem_next = '0; dstep_next = '0;
                end
                else if (nb_ok)
                begin
                    state_next = ST_NB_WAIT;
                end
                else
                begin
                    nb_next = nb_reg + 1'b1;
                end
            end
            ST_NB_WAIT:
            begin
                rd_addr = AW'({nby[CW-1:0], nbx[CW-1:0]});
                state_next = ST_NB_ACC;
            end
            ST_NB_ACC:
            begin
                if (flag_rd[FLAG_FILLED])
                begin
                    if (nb_dist < mn_reg)
                    begin
                        mn_next = nb_dist;
                    end
                    tot_next = tot_reg + 20'(nb_dist);
                    cnt_next = cnt_reg + 1'b1;
                end
                nb_next = nb_reg + 1'b1;
                state_next = ST_NB_RD;
            end
            ST_DIV:
            begin
                // Restoring divider, one quotient bit a cycle.
                if (cnt_reg == '0 || !mode_reg)
                begin
                    sc_next = (cnt_reg == '0) ? NO_NEIGHBOUR_SCORE : mn_reg;
                    state_next = ST_CAND;
                    dstep_next = '0;
                end
                else if (dstep_reg == 5'd20)
                begin
                    sc_next = 17'(quo_reg);
                    state_next = ST_CAND;
                    dstep_next = '0;
                end
                else
                begin
                    if (rem_sh >= {1'b0, cnt_reg})
                    begin
                        rem_next = rem_sh - {1'b0, cnt_reg};
                        quo_next = {quo_reg[18:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        quo_next = {quo_reg[18:0], 1'b0};
                    end
                    dstep_next = dstep_reg + 1'b1;
                end
            end
            ST_CAND:
            begin
                if (dstep_reg != 5'd31 && (!found_reg || sc_reg < best_reg))
                begin
                    found_next = 1'b1;
                    best_next = sc_reg;
                    px_next = x_reg; py_next = y_reg;
                end
                if (x_reg + 9'd1 < side_reg)
                begin
                    x_next = x_reg + 9'd1;
                    state_next = ST_SCAN_RD;
                end
                else if (y_reg + 9'd1 < side_reg)
                begin
                    x_next = '0; y_next = y_reg + 9'd1;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                // The result fields stay in px, py, best and found until the output is free.
                if (kind_reg == KIND_SEARCH && !found_reg)
                begin
                    px_next = '0; py_next = '0; best_next = '0;
                    state_next = ST_OUT;
                end
                else if (px_reg < side_reg && py_reg < side_reg)
                begin
                    found_next = 1'b1;
                    wr_addr = AW'({py_reg[CW-1:0], px_reg[CW-1:0]});
                    colour_we = 1'b1; flag_we = 1'b1;
                    flag_wd = 2'b10;
                    x_next = px_reg; y_next = py_reg; nb_next = '0;
                    state_next = ST_MARK_RD;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_MARK_RD:
            begin
                rd_addr = AW'({nby[CW-1:0], nbx[CW-1:0]});
                if (nb_reg == 4'd9)
                begin
                    state_next = ST_OUT;
                end
                else if (nb_ok)
                begin
                    state_next = ST_MARK_WR;
                end
                else
                begin
                    nb_next = nb_reg + 1'b1;
                end
            end
            ST_MARK_WR:
            begin
                wr_addr = AW'({nby[CW-1:0], nbx[CW-1:0]});
                flag_we = !flag_rd[FLAG_FILLED];
                flag_wd = flag_rd | 2'b01;
                nb_next = nb_reg + 1'b1;
                state_next = ST_MARK_RD;
            end
            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    ox_next = px_reg[7:0]; oy_next = py_reg[7:0];
                    os_next = best_reg; op_next = found_reg;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg) == ST_OUT) else $error("stray result");
    a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        colour_we |-> state_reg == ST_PLACE) else $error("colour write outside place");

endmodule
